// ===== rtl/fp3d_pkg.sv =====
// Shared widths and types for the fixed point 3D distance pipeline.
package fp3d_pkg;

  localparam int FRACTION_BITS = 16;
  localparam int COORD_W       = 32;
  localparam int WHOLE_W       = COORD_W - FRACTION_BITS;
  localparam int MAG_W         = WHOLE_W;
  localparam int SQ_W          = 2 * MAG_W;
  localparam int SUM_W         = SQ_W + 2;
  localparam int ROOT_W        = SUM_W / 2;
  localparam int REM_W         = ROOT_W + 2;
  localparam int DIST_W        = 16;
  localparam int EXT_W         = ROOT_W + DIST_W;
  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  // One word moving down the root chain.
  typedef struct packed {
    logic              valid;
    logic [SUM_W-1:0]  rad;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sqrt_word_t;

endpackage

// ===== rtl/fp3d_in_if.sv =====
// Input channel: two 3D positions in signed fixed point.
interface fp3d_in_if;
  import fp3d_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] first_x;
  logic signed [COORD_W-1:0] first_y;
  logic signed [COORD_W-1:0] first_z;
  logic signed [COORD_W-1:0] second_x;
  logic signed [COORD_W-1:0] second_y;
  logic signed [COORD_W-1:0] second_z;

  modport source (output valid, first_x, first_y, first_z, second_x, second_y, second_z,
                  input ready);
  modport sink   (input valid, first_x, first_y, first_z, second_x, second_y, second_z,
                  output ready);
endinterface

// ===== rtl/fp3d_out_if.sv =====
// Result channel: integer distance.
interface fp3d_out_if;
  import fp3d_pkg::*;

  logic              valid;
  logic              ready;
  logic [DIST_W-1:0] distance;

  modport source (output valid, distance, input ready);
  modport sink   (input valid, distance, output ready);
endinterface

// ===== rtl/fp3d_front.sv =====
// Front end: axis deltas, squares and their sum, three register stages.
module fp3d_front (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               en,
  input  logic                               in_valid,
  input  logic signed [fp3d_pkg::COORD_W-1:0] first_x,
  input  logic signed [fp3d_pkg::COORD_W-1:0] first_y,
  input  logic signed [fp3d_pkg::COORD_W-1:0] first_z,
  input  logic signed [fp3d_pkg::COORD_W-1:0] second_x,
  input  logic signed [fp3d_pkg::COORD_W-1:0] second_y,
  input  logic signed [fp3d_pkg::COORD_W-1:0] second_z,
  output fp3d_pkg::sqrt_word_t               sum_word
);
  import fp3d_pkg::*;

  // Whole-unit magnitude of a wrapped difference, arithmetic shift.
  function automatic logic [MAG_W-1:0] mag_of(input logic signed [COORD_W-1:0] a,
                                              input logic signed [COORD_W-1:0] b);
    logic signed [COORD_W-1:0] d;
    logic signed [COORD_W-1:0] sh;
    logic [MAG_W-1:0]          w;
    d  = a - b;
    sh = d >>> FRACTION_BITS;
    w  = sh[MAG_W-1:0];
    return w[MAG_W-1] ? (~w + 1'b1) : w;
  endfunction

  logic             v1_r, v2_r, v3_r;
  logic [MAG_W-1:0] mx_r, my_r, mz_r;
  logic [SQ_W-1:0]  sx_r, sy_r, sz_r;
  logic [SUM_W-1:0] sum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mx_r  <= mag_of(first_x, second_x);
      my_r  <= mag_of(first_y, second_y);
      mz_r  <= mag_of(first_z, second_z);
      sx_r  <= mx_r * mx_r;
      sy_r  <= my_r * my_r;
      sz_r  <= mz_r * mz_r;
      sum_r <= SUM_W'(sx_r) + SUM_W'(sy_r) + SUM_W'(sz_r);
    end
  end

  always_comb begin
    sum_word.valid = v3_r;
    sum_word.rad   = sum_r;
    sum_word.rem   = '0;
    sum_word.root  = '0;
  end
endmodule

// ===== rtl/fp3d_sqrt_cell.sv =====
// One root digit: brings in two radicand bits and decides one root bit.
module fp3d_sqrt_cell (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  fp3d_pkg::sqrt_word_t word_in,
  output fp3d_pkg::sqrt_word_t word_out
);
  import fp3d_pkg::*;

  sqrt_word_t        word_r, word_nxt;
  logic [REM_W-1:0]  rem_sh;
  logic [REM_W-1:0]  trial;
  logic              fits;

  always_comb begin
    rem_sh = {word_in.rem[REM_W-3:0], word_in.rad[SUM_W-1 -: 2]};
    trial  = {word_in.root, 2'b01};
    fits   = rem_sh >= trial;
    word_nxt.valid = word_in.valid;
    word_nxt.rad   = {word_in.rad[SUM_W-3:0], 2'b00};
    word_nxt.rem   = fits ? (rem_sh - trial) : rem_sh;
    word_nxt.root  = {word_in.root[ROOT_W-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_r.valid <= 1'b0;
    end else if (en) begin
      word_r.valid <= word_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      word_r.rad  <= word_nxt.rad;
      word_r.rem  <= word_nxt.rem;
      word_r.root <= word_nxt.root;
    end
  end

  assign word_out = word_r;
endmodule

// ===== rtl/fixed_point_3d_distance.sv =====
// Top level: integer Euclidean distance between two fixed point 3D positions.
//
//   channel   dir   payload                                   handshake
//   in_ch     in    first_x/y/z, second_x/y/z  (s32 each)     valid/ready
//   out_ch    out   distance (u16)                            valid/ready
//
// One word accepted per cycle while the output is not stalled; the path runs
// through the delta, square and sum stages, one root cell per root bit,
// then the output register.
// Reset (synchronous, rst_n low) empties the pipeline.
// A stalled output freezes the whole pipeline; in_ch.ready follows that.
module fixed_point_3d_distance (
  input logic       clk,
  input logic       rst_n,
  fp3d_in_if.sink   in_ch,
  fp3d_out_if.source out_ch
);
  import fp3d_pkg::*;

  logic              en;
  sqrt_word_t        chain [ROOT_W+1];
  logic [EXT_W-1:0]  root_ext;
  logic [DIST_W-1:0] dist_nxt;
  logic              out_valid_r;
  logic [DIST_W-1:0] dist_r;

  assign en       = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;

  fp3d_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_ch.valid),
    .first_x  (in_ch.first_x),
    .first_y  (in_ch.first_y),
    .first_z  (in_ch.first_z),
    .second_x (in_ch.second_x),
    .second_y (in_ch.second_y),
    .second_z (in_ch.second_z),
    .sum_word (chain[0])
  );

  for (genvar i = 0; i < ROOT_W; i++) begin : g_cell
    fp3d_sqrt_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .word_in  (chain[i]),
      .word_out (chain[i+1])
    );
  end

  // saturate the root to the result width
  always_comb begin
    root_ext = EXT_W'(chain[ROOT_W].root);
    dist_nxt = (root_ext > EXT_W'(DIST_MAX)) ? DIST_MAX : root_ext[DIST_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= chain[ROOT_W].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dist_r <= dist_nxt;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.distance = dist_r;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_ch.valid)
    else $error("output valid right after reset");

  a_last_cell_to_out: assert property (@(posedge clk) disable iff (!rst_n)
      (chain[ROOT_W].valid && en) |=> out_ch.valid)
    else $error("word lost between last root cell and output");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
      (out_ch.valid && !out_ch.ready) |=> out_ch.valid && $stable(out_ch.distance))
    else $error("output word changed while waiting");

  a_stall_freezes_chain: assert property (@(posedge clk) disable iff (!rst_n)
      !en |=> $stable(chain[ROOT_W].valid) && $stable(chain[ROOT_W].root))
    else $error("root chain moved during output stall");
endmodule
